// ===== sv/sls_pkg.sv =====
// shared types and constants of the slope limiter stencil
package sls_pkg;

	localparam int VALUE_WIDTH_DEF = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam int PADDR_WIDTH = 3;
	localparam int PDATA_WIDTH = 32;
	localparam int SLOPE_WIDTH = 32;

	localparam logic [PADDR_WIDTH-1:0] ADDR_LIMITER_MODE = 3'd0;

	localparam logic [1:0] MODE_MINMOD = 2'd0;
	localparam logic [1:0] MODE_VAN_LEER = 2'd1;
	localparam logic [1:0] MODE_MC = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_VAN_LEER;

	localparam logic [1:0] FILL_FULL = 2'd2;

	typedef enum logic [1:0] {
		OP_ZERO,
		OP_MINMOD,
		OP_VAN_LEER,
		OP_MC
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== sv/slope_limiter_stencil.sv =====
// top level of the slope limiter stencil: config register, front, queue, back
// path: an accepted cell that fills the window is written to the queue, popped by the back end and
// loaded into the output register; van leer slopes first pass through the ST_DIV and ST_DONE states
// throughput: one item per cycle into the queue while not full; the back end retires one slope
// per cycle for minmod, mc and zero slopes while the output is not stalled, and takes no new item
// in the radix-2 van leer loop; reset clears window, queue and output, mode resets to van leer
module slope_limiter_stencil #(
	parameter int VALUE_WIDTH = sls_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sls_pkg::PADDR_WIDTH-1:0]    paddr,
	input  logic [sls_pkg::PDATA_WIDTH-1:0]    pwdata,
	output logic [sls_pkg::PDATA_WIDTH-1:0]    prdata,
	output logic                               pready,
	input  logic signed [VALUE_WIDTH-1:0]      cell_value,
	input  logic                               line_start,
	input  logic                               cell_valid,
	output logic                               cell_ready,
	output logic signed [sls_pkg::SLOPE_WIDTH-1:0] limited_slope,
	output logic                               slope_valid,
	input  logic                               slope_ready
);
	import sls_pkg::*;

	localparam int DW = VALUE_WIDTH + 1;
	localparam int QW = 2 + 2 * DW;

	logic [1:0]              mode_q;
	logic                    mode_write;
	queue_status_t           queue_status;
	logic                    push, pop;
	op_t                     push_op, head_op;
	logic signed [DW-1:0]    push_dl, push_dr, head_dl, head_dr;
	logic [QW-1:0]           head_data;
	logic [SLOPE_WIDTH-1:0]  slope_bits;

	assign pready = 1'b1;
	assign mode_write = psel && penable && pwrite && pready
		&& (paddr == ADDR_LIMITER_MODE);
	assign prdata = (paddr == ADDR_LIMITER_MODE) ? PDATA_WIDTH'(mode_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (mode_write) begin
			mode_q <= pwdata[1:0];
		end
	end

	sls_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_value  (cell_value),
		.line_start  (line_start),
		.cell_valid  (cell_valid),
		.cell_ready  (cell_ready),
		.mode        (mode_q),
		.queue_status(queue_status),
		.push        (push),
		.push_op     (push_op),
		.push_dl     (push_dl),
		.push_dr     (push_dr)
	);

	sls_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_op, push_dl, push_dr}),
		.pop      (pop),
		.pop_data (head_data),
		.status   (queue_status)
	);

	assign head_op = op_t'(head_data[QW-1 -: 2]);
	assign head_dl = head_data[2*DW-1 -: DW];
	assign head_dr = head_data[DW-1:0];

	sls_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_status (queue_status),
		.pop          (pop),
		.head_op      (head_op),
		.head_dl      (head_dl),
		.head_dr      (head_dr),
		.slope_valid  (slope_valid),
		.slope_ready  (slope_ready),
		.limited_slope(slope_bits)
	);

	assign limited_slope = slope_bits;

endmodule

// ===== sv/sls_queue.sv =====
// two-entry queue between the classifying front and the limiter back end
module sls_queue #(
	parameter int WIDTH = 66
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      pop_data,
	output sls_pkg::queue_status_t status
);
	import sls_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
		if (ptr == PW'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + PW'(1);
	endfunction

	assign status.full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue read while empty");

endmodule

// ===== sv/sls_front.sv =====
// front end: cell window, neighbor differences and limiter classification
module sls_front #(
	parameter int VALUE_WIDTH = sls_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] cell_value,
	input  logic                          line_start,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  logic [1:0]                    mode,
	input  sls_pkg::queue_status_t        queue_status,
	output logic                          push,
	output sls_pkg::op_t                  push_op,
	output logic signed [VALUE_WIDTH:0]   push_dl,
	output logic signed [VALUE_WIDTH:0]   push_dr
);
	import sls_pkg::*;

	localparam int DW = VALUE_WIDTH + 1;

	logic signed [VALUE_WIDTH-1:0] centre_q;
	logic signed [VALUE_WIDTH-1:0] left_q;
	logic [1:0]                    fill_q;
	logic [1:0]                    fill_eff;
	logic                          accept;
	logic                          no_slope;

	assign cell_ready = !queue_status.full;
	assign accept = cell_valid && cell_ready;
	assign fill_eff = line_start ? 2'd0 : fill_q;
	assign push = accept && (fill_eff == FILL_FULL);

	assign push_dl = DW'(centre_q) - DW'(left_q);
	assign push_dr = DW'(cell_value) - DW'(centre_q);

	// opposite signs or a flat side give a zero slope
	assign no_slope = (push_dl == '0) || (push_dr == '0)
		|| (push_dl[DW-1] != push_dr[DW-1]);

	always_comb begin
		if (no_slope) begin
			push_op = OP_ZERO;
		end else begin
			unique case (mode)
				MODE_VAN_LEER: push_op = OP_VAN_LEER;
				MODE_MC:       push_op = OP_MC;
				default:       push_op = OP_MINMOD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			centre_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= centre_q;
			centre_q <= cell_value;
			fill_q <= (fill_eff == FILL_FULL) ? fill_eff : fill_eff + 2'd1;
		end
	end

endmodule

// ===== sv/sls_back.sv =====
// back end: limiter arithmetic, iterative van leer mul-div and output register
module sls_back #(
	parameter int VALUE_WIDTH = sls_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sls_pkg::queue_status_t            queue_status,
	output logic                              pop,
	input  sls_pkg::op_t                      head_op,
	input  logic signed [VALUE_WIDTH:0]       head_dl,
	input  logic signed [VALUE_WIDTH:0]       head_dr,
	output logic                              slope_valid,
	input  logic                              slope_ready,
	output logic [sls_pkg::SLOPE_WIDTH-1:0]   limited_slope
);
	import sls_pkg::*;

	localparam int DW = VALUE_WIDTH + 1;
	localparam int SW = VALUE_WIDTH + 2;
	localparam int EW = (DW > SLOPE_WIDTH + 1) ? DW : SLOPE_WIDTH + 1;
	localparam int CW = $clog2(DW);
	localparam logic [EW-1:0] POS_LIMIT = EW'(64'h7FFF_FFFF);
	localparam logic [EW-1:0] NEG_LIMIT = EW'(64'h8000_0000);
	localparam logic [SLOPE_WIDTH-1:0] SAT_HI = 32'h7FFF_FFFF;
	localparam logic [SLOPE_WIDTH-1:0] SAT_LO = 32'h8000_0000;

	back_state_t state_q, state_d;

	logic [DW-1:0]  ma, mb, min_mag, simple_mag;
	logic [SW-1:0]  sum_mag;
	logic           head_neg, mc_tight;

	logic [SW-1:0]  x_q, s_q, r_q;
	logic [DW-1:0]  y_q, q_q;
	logic [CW-1:0]  cnt_q;
	logic           neg_q;
	logic [SW:0]    r2, s2;
	logic [SW-1:0]  r_next;
	logic [DW-1:0]  q_next;

	logic                   out_free, load, div_start;
	logic [SLOPE_WIDTH-1:0] load_data;
	logic                   slope_valid_q;
	logic [SLOPE_WIDTH-1:0] slope_q;

	function automatic logic [SLOPE_WIDTH-1:0] saturate(input logic neg,
		input logic [DW-1:0] mag);
		logic [EW-1:0]          wide;
		logic [SLOPE_WIDTH-1:0] low;
		wide = EW'(mag);
		low = wide[SLOPE_WIDTH-1:0];
		if (!neg && (wide > POS_LIMIT)) begin
			return SAT_HI;
		end
		if (neg && (wide > NEG_LIMIT)) begin
			return SAT_LO;
		end
		return neg ? -low : low;
	endfunction

	// both sides share one sign here, so everything works on magnitudes
	assign head_neg = head_dl[DW-1];
	assign ma = head_dl[DW-1] ? DW'(-head_dl) : DW'(head_dl);
	assign mb = head_dr[DW-1] ? DW'(-head_dr) : DW'(head_dr);
	assign sum_mag = SW'(ma) + SW'(mb);
	assign min_mag = (ma < mb) ? ma : mb;
	assign mc_tight = ((SW+1)'(sum_mag) < {ma, 2'b00})
		&& ((SW+1)'(sum_mag) < {mb, 2'b00});

	always_comb begin
		unique case (head_op)
			OP_MINMOD: simple_mag = min_mag >> 1;
			OP_MC:     simple_mag = mc_tight ? DW'(sum_mag >> 2) : min_mag;
			default:   simple_mag = '0;
		endcase
	end

	// one mul-div step: remainder stays below the sum, so it drops 0, 1 or 2 sums
	assign r2 = {r_q, 1'b0} + (y_q[DW-1] ? {1'b0, x_q} : '0);
	assign s2 = {s_q, 1'b0};
	always_comb begin
		if (r2 >= s2) begin
			r_next = SW'(r2 - s2);
			q_next = {q_q[DW-2:0], 1'b0} + DW'(2);
		end else if (r2 >= {1'b0, s_q}) begin
			r_next = SW'(r2 - {1'b0, s_q});
			q_next = {q_q[DW-2:0], 1'b0} + DW'(1);
		end else begin
			r_next = SW'(r2);
			q_next = {q_q[DW-2:0], 1'b0};
		end
	end

	assign out_free = !slope_valid_q || slope_ready;

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load = 1'b0;
		load_data = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!queue_status.empty && out_free) begin
					pop = 1'b1;
					if (head_op == OP_VAN_LEER) begin
						div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						load = 1'b1;
						load_data = saturate(head_neg, simple_mag);
					end
				end
			end
			ST_DIV: begin
				if (cnt_q == CW'(DW - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load = 1'b1;
					load_data = saturate(neg_q, q_q);
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slope_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				slope_valid_q <= 1'b1;
			end else if (slope_ready) begin
				slope_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slope_q <= load_data;
		end
		if (div_start) begin
			x_q <= SW'(ma);
			y_q <= mb;
			s_q <= sum_mag;
			r_q <= '0;
			q_q <= '0;
			cnt_q <= '0;
			neg_q <= head_neg;
		end else if (state_q == ST_DIV) begin
			y_q <= {y_q[DW-2:0], 1'b0};
			r_q <= r_next;
			q_q <= q_next;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign slope_valid = slope_valid_q;
	assign limited_slope = slope_q;

	a_rem_below_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (r_q < s_q))
		else $error("mul-div remainder not below divisor");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ($past(state_q) == ST_DIV || $past(state_q) == ST_DONE))
		else $error("result stage entered without a divide");

endmodule
